/* design/assert_macros.svh */
// Assertion macros for use in the design files.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AST_SAME(lbl, ante, cons, msg)
`define AST_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/gmcd_pkg.sv */
package gmcd_pkg;

  localparam int SAMPLES   = 16;
  localparam int CNT_W     = $clog2(SAMPLES);
  localparam int RAW_W     = 16;
  localparam int DEPTH_W   = 15;
  localparam int TDATA_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 1'd1;

  localparam logic [DEPTH_W-1:0] LOW_BOUND_RST  = 15'd499;
  localparam logic [DEPTH_W-1:0] HIGH_BOUND_RST = 15'd4501;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
  localparam int MEDIAN_POS = SAMPLES / 2;

  typedef struct packed {
    logic             insert;
    logic [CNT_W-1:0] fill;
    logic             load_out;
  } gmcd_cmd_t;

endpackage

/* design/gmcd_datapath.sv */
module gmcd_datapath
  import gmcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  gmcd_cmd_t            cmd,
  input  logic [RAW_W-1:0]     raw_depth,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DEPTH_W-1:0]   cfg_wdata,
  output logic [DEPTH_W-1:0]   cell_depth,
  output logic                 has_depth
);

  logic [DEPTH_W-1:0] low_bound_r, low_bound_nxt;
  logic [DEPTH_W-1:0] high_bound_r, high_bound_nxt;
  logic [DEPTH_W-1:0] sorted_r [SAMPLES];
  logic [DEPTH_W-1:0] sorted_nxt [SAMPLES];
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] gated;
  logic [DEPTH_W-1:0] raw_low;
  logic [SAMPLES-1:0] keep;

  assign raw_low = raw_depth[DEPTH_W-1:0];

  always_comb begin
    if (!raw_depth[RAW_W-1] && raw_low > low_bound_r && raw_low < high_bound_r) begin
      gated = raw_low;
    end else begin
      gated = '0;
    end
  end

  // An entry stays where it is if it is filled and not above the new sample.
  always_comb begin
    for (int p = 0; p < SAMPLES; p++) begin
      keep[p] = (CNT_W'(p) < cmd.fill) && (sorted_r[p] <= gated);
    end
  end

  for (genvar p = 0; p < SAMPLES; p++) begin : g_cell
    if (p == 0) begin : g_head
      assign sorted_nxt[p] = keep[p] ? sorted_r[p] : gated;
    end else begin : g_body
      assign sorted_nxt[p] = keep[p]   ? sorted_r[p] :
                             keep[p-1] ? gated       : sorted_r[p-1];
    end
  end

  always_comb begin
    low_bound_nxt  = low_bound_r;
    high_bound_nxt = high_bound_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_BOUND:  low_bound_nxt  = cfg_wdata;
        CFG_HIGH_BOUND: high_bound_nxt = cfg_wdata;
        default: ;
      endcase
    end
    depth_nxt = cmd.load_out ? sorted_nxt[MEDIAN_POS] : depth_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bound_r  <= LOW_BOUND_RST;
      high_bound_r <= HIGH_BOUND_RST;
    end else begin
      low_bound_r  <= low_bound_nxt;
      high_bound_r <= high_bound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      sorted_r <= sorted_nxt;
    end
    depth_r <= depth_nxt;
  end

  assign cell_depth = depth_r;
  assign has_depth  = (depth_r != '0);

endmodule

/* design/gmcd_ctrl.sv */
module gmcd_ctrl
  import gmcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output gmcd_cmd_t cmd
);
`include "assert_macros.svh"

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last;
  logic             in_fire;
  logic             out_fire;

  assign last      = (count_r == CNT_LAST);
  assign out_fire  = (state_r == ST_FULL) && out_tready;
  assign in_tready = !(last && (state_r == ST_FULL) && !out_tready);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    count_nxt = count_r;
    if (in_fire) begin
      count_nxt = last ? '0 : count_r + 1'b1;
    end
    state_nxt = state_r;
    priority if (in_fire && last) begin
      state_nxt = ST_FULL;
    end else if (out_fire) begin
      state_nxt = ST_EMPTY;
    end else begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_tvalid   = (state_r == ST_FULL);
  assign cmd.insert   = in_fire;
  assign cmd.fill     = count_r;
  assign cmd.load_out = in_fire && last;

  `AST_NEXT(a_last_gives_result, in_fire && last, out_tvalid && count_r == '0,
            "closing word of a cell did not produce a result")
  `AST_NEXT(a_count_steps, in_fire && !last, count_r == $past(count_r) + 1'b1,
            "sample count did not advance")
  `AST_SAME(a_stall_only_on_last, !in_tready, last && out_tvalid && !out_tready,
            "input stalled without a pending result")

endmodule

/* design/gated_median_cell_downscale.sv */
// Gated median cell downscaler.
// The in_ channel carries one raw 16-bit depth word per handshake. Each word
// is gated against the low and high bounds (exclusive); words outside them,
// and words with the top bit set, count as zero. Every group of SAMPLES words
// forms one cell, and the out_ channel then carries one word with the upper
// median of that cell in out_tdata and the nonzero flag in out_tuser.
// Words are sorted into a row of compare-and-shift cells as they arrive, so
// the input side runs at one word per cycle while no result is held up.
// The result is valid in the cycle after the last word of a cell is
// accepted and is held in an output register until taken.
// If the receiver stalls, input keeps flowing until the last word of the
// next cell, which waits until the pending result is taken.
// Bounds are written on the cfg_ port: index 0 is the low bound, index 1 the
// high bound; new bounds apply from the next word on.
// A synchronous reset restores the default bounds, discards a partial cell
// and drops any pending result; no clearing pass is needed.
module gated_median_cell_downscale
  import gmcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // [15:0] raw_depth
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,  // [14:0] cell_depth, [15] zero
  output logic                 out_tuser,  // [0] has_depth
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DEPTH_W-1:0]   cfg_wdata
);

  gmcd_cmd_t          cmd;
  logic [DEPTH_W-1:0] cell_depth;

  gmcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gmcd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .raw_depth  (in_tdata[RAW_W-1:0]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cell_depth (cell_depth),
    .has_depth  (out_tuser)
  );

  assign out_tdata = {{(TDATA_W-DEPTH_W){1'b0}}, cell_depth};

endmodule

/* test/cell_median_checker.sv */
`timescale 1ns / 100ps

module cell_median_checker
  import gmcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // [15:0] raw_depth
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [TDATA_W-1:0]   out_tdata,  // [14:0] cell_depth, [15] zero
  input  logic                 out_tuser,  // [0] has_depth
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DEPTH_W-1:0]   cfg_wdata,
  output int                   mismatches,
  output int                   pending_cells,
  output int                   cells_seen,
  output int                   empty_cells
);

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               has_depth;
  } cell_result_t;

  logic [DEPTH_W-1:0] lo_bound;
  logic [DEPTH_W-1:0] hi_bound;
  logic [DEPTH_W-1:0] cell_words [SAMPLES];
  logic [DEPTH_W-1:0] gated;
  logic [DEPTH_W-1:0] median;
  cell_result_t       expected_cells [$];
  cell_result_t       head;
  int                 fill;
  int                 below;
  int                 at_or_below;
  int                 i;
  int                 j;

  always @(posedge clk) begin
    if (!rst_n) begin
      lo_bound = LOW_BOUND_RST;
      hi_bound = HIGH_BOUND_RST;
      fill = 0;
      expected_cells.delete();
      mismatches = 0;
      pending_cells = 0;
      cells_seen = 0;
      empty_cells = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          $error("Result word with no cell pending: cell_depth %0d, has_depth %0d",
                 out_tdata[DEPTH_W-1:0], out_tuser);
        end else begin
          head = expected_cells.pop_front();
          cells_seen++;
          if (out_tdata !== {1'b0, head.depth}) begin
            mismatches++;
            $error("cell_depth mismatch: expected %0d, actual %0d",
                   {1'b0, head.depth}, out_tdata);
          end
          if (out_tuser !== head.has_depth) begin
            mismatches++;
            $error("has_depth mismatch: expected %0d, actual %0d",
                   head.has_depth, out_tuser);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        // A word with the top bit set never passes the bounds compare.
        if (!in_tdata[RAW_W-1] && in_tdata[DEPTH_W-1:0] > lo_bound &&
            in_tdata[DEPTH_W-1:0] < hi_bound) begin
          gated = in_tdata[DEPTH_W-1:0];
        end else begin
          gated = '0;
        end
        cell_words[fill[CNT_W-1:0]] = gated;
        fill++;
        if (fill == SAMPLES) begin
          fill = 0;
          median = '0;
          for (i = 0; i < SAMPLES; i++) begin
            below = 0;
            at_or_below = 0;
            for (j = 0; j < SAMPLES; j++) begin
              if (cell_words[j[CNT_W-1:0]] < cell_words[i[CNT_W-1:0]]) below++;
              if (cell_words[j[CNT_W-1:0]] <= cell_words[i[CNT_W-1:0]]) at_or_below++;
            end
            if (below <= MEDIAN_POS && at_or_below > MEDIAN_POS) begin
              median = cell_words[i[CNT_W-1:0]];
            end
          end
          expected_cells.push_back('{depth: median, has_depth: (median != '0)});
          if (median == '0) empty_cells++;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_LOW_BOUND: begin
            lo_bound = cfg_wdata;
          end
          CFG_HIGH_BOUND: begin
            hi_bound = cfg_wdata;
          end
        endcase
      end

      pending_cells = expected_cells.size();
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import gmcd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTINGS_COUNT = 14;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LOW_BOUND;
  logic [DEPTH_W-1:0]   cfg_wdata = '0;

  int mismatches;
  int pending_cells;
  int cells_seen;
  int empty_cells;
  int stalled = 0;
  int words_sent = 0;
  int settings_used = 0;
  bit steady = 1'b0;

  logic [RAW_W-1:0] early_words [8] = '{16'd0, 16'hFFFF, 16'h8000, 16'h7FFF,
                                        16'd499, 16'd500, 16'd4500, 16'd4501};
  logic [RAW_W-1:0] late_words [8] = '{16'd1, 16'd32766, 16'd32767, 16'd2,
                                       16'd3, 16'd4, 16'd5, 16'h8001};

  gated_median_cell_downscale i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  cell_median_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .pending_cells (pending_cells),
    .cells_seen    (cells_seen),
    .empty_cells   (empty_cells)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stalled <= 0;
      end else if (stalled >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stalled <= stalled + 1;
      end
    end
  end

  task automatic send_word(input logic [RAW_W-1:0] word);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_cells != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_bounds(input logic [DEPTH_W-1:0] lo, input logic [DEPTH_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOW_BOUND;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_HIGH_BOUND;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int p;
    int k;
    int n;
    int r;
    int lo;
    int hi;
    int word;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The second half of this cell is gated under different bounds than the first.
    for (k = 0; k < 8; k++) send_word(early_words[k[2:0]]);
    drain();
    set_bounds(15'd0, 15'd32767);
    for (k = 0; k < 8; k++) send_word(late_words[k[2:0]]);
    drain();

    for (p = 0; p < SETTINGS_COUNT; p++) begin
      case (p % 7)
        0: begin
          lo = 0;
          hi = 32767;
        end
        1: begin
          lo = 32767;
          hi = 0;
        end
        2: begin
          lo = 100;
          hi = 101;
        end
        3: begin
          lo = 100;
          hi = 102;
        end
        4: begin
          lo = 499;
          hi = 4501;
        end
        5: begin
          lo = $urandom_range(0, 30000);
          hi = lo + $urandom_range(2, 2767);
        end
        default: begin
          lo = $urandom_range(0, 32767);
          hi = $urandom_range(0, 32767);
        end
      endcase
      set_bounds(lo[DEPTH_W-1:0], hi[DEPTH_W-1:0]);
      steady <= (p == 3 || p == 10);
      n = $urandom_range(100, 156);
      for (k = 0; k < n; k++) begin
        if (p == 7 && k == 60) drain();
        r = $urandom_range(0, 99);
        if (r < 60) begin
          word = $urandom_range((lo > 2) ? lo - 2 : 0, (hi < 32765) ? hi + 2 : 32767);
        end else if (r < 80) begin
          word = $urandom_range(0, 65535);
        end else begin
          case ($urandom_range(0, 7))
            0: word = 0;
            1: word = 32767;
            2: word = 32768;
            3: word = 65535;
            4: word = lo;
            5: word = lo + 1;
            6: word = hi - 1;
            default: word = hi;
          endcase
        end
        send_word(word[RAW_W-1:0]);
      end
      drain();
    end

    $display("Sent %0d depth words under %0d bound settings.", words_sent, settings_used);
    $display("Checked %0d cells, %0d of them empty.", cells_seen, empty_cells);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/gmcd_pkg.sv
design/gmcd_datapath.sv
design/gmcd_ctrl.sv
design/gated_median_cell_downscale.sv
test/cell_median_checker.sv
test/testbench.sv
